### sv/tcw_pkg.sv
// Shared constants for the text console writer: geometry defaults, opcodes and cell codes.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int OPCODE_W  = 2;
    localparam int CHAR_W    = 8;
    localparam int ADDR_W    = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int CELL_W    = 16;
    localparam int ATTR_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_ATTR = 1'd1;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_ATTR, SPACE_CODE};

endpackage

### sv/tcw_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/text_console_writer.sv
// Put, newline and read go through ST_POST, and from there their result is registered in the output register.
// A scroll first blanks the new bottom row, and a clear the whole screen, in ST_BLANK.
// Items are taken one at a time; ST_POST waits while a stalled result still holds the output register.
// A new item is taken while the previous result still waits in the output register.
// Reset: asynchronous, active low; afterwards a clearing pass over all ROWS*COLUMNS cells
// fills the memory with blank cells while in_ready stays low (configuration writes still land).
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcw_pkg::ATTR_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tcw_pkg::OPCODE_W-1:0]    opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]      character,
    input  logic [tcw_pkg::ADDR_W-1:0]      cell_address,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]   cursor_column,
    output logic [tcw_pkg::ADDR_W-1:0]      cursor_index,
    output logic [tcw_pkg::CELL_W-1:0]      cell_data,
    output logic                            scrolled
);

    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int SW    = ((AW > ADDR_W) ? AW : ADDR_W) + 1;

    localparam logic [SW-1:0] CELLS_S   = SW'(CELLS);
    localparam logic [SW-1:0] COLUMNS_S = SW'(COLUMNS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_BLANK = 2'd2;
    localparam logic [1:0] ST_POST  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     top_reg, top_next;
    logic [AW-1:0]     sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0]     sweep_last_reg, sweep_last_next;
    logic              read_ok_reg, read_ok_next;
    logic              scrolled_reg, scrolled_next;
    logic [ATTR_W-1:0] text_attr_reg;
    logic [ATTR_W-1:0] clear_attr_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [ROW_OUT_W-1:0]  out_row_reg, out_row_next;
    logic [COL_OUT_W-1:0]  out_col_reg, out_col_next;
    logic [ADDR_W-1:0]     out_idx_reg, out_idx_next;
    logic [CELL_W-1:0]     out_data_reg, out_data_next;
    logic                  out_scr_reg, out_scr_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic              in_fire;
    logic              out_free;
    logic [SW-1:0]     cur_sum, cur_phys, rd_sum, rd_phys, top_sum;
    logic [CW:0]       col_inc;
    logic [RW:0]       row_inc;
    logic              addr_ok;
    logic [31:0]       row_ext, col_ext, idx_ext;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // The screen rotates: top_reg is the physical address of logical cell zero.
    assign cur_sum  = SW'(idx_reg) + SW'(top_reg);
    assign cur_phys = (cur_sum >= CELLS_S) ? (cur_sum - CELLS_S) : cur_sum;
    assign rd_sum   = SW'(cell_address) + SW'(top_reg);
    assign rd_phys  = (rd_sum >= CELLS_S) ? (rd_sum - CELLS_S) : rd_sum;
    assign top_sum  = SW'(top_reg) + COLUMNS_S;
    assign addr_ok  = SW'(cell_address) < CELLS_S;
    assign col_inc  = {1'b0, col_reg} + (CW+1)'(1);
    assign row_inc  = {1'b0, row_reg} + (RW+1)'(1);

    assign row_ext = 32'(row_reg);
    assign col_ext = 32'(col_reg);
    assign idx_ext = 32'(idx_reg);

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        idx_next        = idx_reg;
        top_next        = top_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        read_ok_next    = read_ok_reg;
        scrolled_next   = scrolled_reg;
        ram_we          = 1'b0;
        ram_waddr       = sweep_addr_reg;
        ram_wdata       = {clear_attr_reg, SPACE_CODE};
        ram_re          = 1'b0;
        ram_raddr       = rd_phys[AW-1:0];

        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = RESET_CELL;
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    read_ok_next  = 1'b0;
                    scrolled_next = 1'b0;
                    state_next    = ST_POST;
                    case (opcode)
                        OP_PUT:
                        begin
                            if (character != NEWLINE_CODE)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cur_phys[AW-1:0];
                                ram_wdata = {text_attr_reg, character};
                            end
                            if (character == NEWLINE_CODE || col_inc >= (CW+1)'(COLUMNS))
                            begin
                                col_next = '0;
                                if (row_inc >= (RW+1)'(ROWS))
                                begin
                                    // Scroll: advance the top row and blank the old top row,
                                    // which becomes the new bottom row.
                                    row_next        = LAST_ROW;
                                    idx_next        = LAST_ROW_BASE;
                                    top_next        = (top_sum >= CELLS_S) ?
                                                      AW'(top_sum - CELLS_S) : AW'(top_sum);
                                    sweep_addr_next = top_reg;
                                    sweep_last_next = AW'(SW'(top_reg) + COLUMNS_S - SW'(1));
                                    scrolled_next   = 1'b1;
                                    state_next      = ST_BLANK;
                                end
                                else
                                begin
                                    row_next = row_inc[RW-1:0];
                                    idx_next = AW'(SW'(idx_reg) + COLUMNS_S - SW'(col_reg));
                                end
                            end
                            else
                            begin
                                col_next = col_inc[CW-1:0];
                                idx_next = idx_reg + AW'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            row_next        = '0;
                            col_next        = '0;
                            idx_next        = '0;
                            sweep_addr_next = '0;
                            sweep_last_next = LAST_CELL;
                            state_next      = ST_BLANK;
                        end
                        OP_READ:
                        begin
                            ram_re       = 1'b1;
                            read_ok_next = addr_ok;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BLANK:
            begin
                ram_we = 1'b1;
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    state_next = ST_POST;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + AW'(1);
                end
            end
            ST_POST:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_idx_next   = out_idx_reg;
        out_data_next  = out_data_reg;
        out_scr_next   = out_scr_reg;
        if (state_reg == ST_POST && out_free)
        begin
            out_valid_next = 1'b1;
            out_row_next   = row_ext[ROW_OUT_W-1:0];
            out_col_next   = col_ext[COL_OUT_W-1:0];
            out_idx_next   = idx_ext[ADDR_W-1:0];
            // Read data stays put: no new read is issued until this result is registered for output.
            out_data_next  = read_ok_reg ? ram_rdata : '0;
            out_scr_next   = scrolled_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            row_reg        <= '0;
            col_reg        <= '0;
            idx_reg        <= '0;
            top_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_last_reg <= LAST_CELL;
            read_ok_reg    <= 1'b0;
            scrolled_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            text_attr_reg  <= RESET_ATTR;
            clear_attr_reg <= RESET_ATTR;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            idx_reg        <= idx_next;
            top_reg        <= top_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            read_ok_reg    <= read_ok_next;
            scrolled_reg   <= scrolled_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TEXT_ATTR:  text_attr_reg  <= cfg_data;
                    CFG_CLEAR_ATTR: clear_attr_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_idx_reg  <= out_idx_next;
        out_data_reg <= out_data_next;
        out_scr_reg  <= out_scr_next;
    end

    assign out_valid     = out_valid_reg;
    assign cursor_row    = out_row_reg;
    assign cursor_column = out_col_reg;
    assign cursor_index  = out_idx_reg;
    assign cell_data     = out_data_reg;
    assign scrolled      = out_scr_reg;

endmodule

### sv/tcw_checker.sv
// Port-level checker for the text console writer and its bind to the top level.
module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row,
    input logic [tcw_pkg::COL_OUT_W-1:0] cursor_column,
    input logic [tcw_pkg::ADDR_W-1:0]    cursor_index,
    input logic                          scrolled
);

    import tcw_pkg::*;

    localparam logic [31:0] ROW_LAST = 32'(ROWS - 1);
    localparam logic        FITS     = (ROWS <= 32) && (COLUMNS <= 128);

    logic [31:0] lin_idx;
    assign lin_idx = 32'(cursor_row) * 32'(COLUMNS) + 32'(cursor_column);

    // A stalled result must stay offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // When the geometry fits the output widths, the reported linear index matches the reported row and column.
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        FITS && out_valid |-> cursor_index == lin_idx[ADDR_W-1:0])
        else $error("cursor index disagrees with row and column");

    // When the geometry fits the output widths, a scroll leaves the cursor at the start of the bottom row.
    a_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        FITS && out_valid && scrolled |->
            cursor_row == ROW_LAST[ROW_OUT_W-1:0] && cursor_column == '0)
        else $error("scroll left the cursor off the bottom row start");

    // Items are handled one at a time: the input side closes after each transfer.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in progress");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column),
    .cursor_index  (cursor_index),
    .scrolled      (scrolled)
);

### tb/console_checker.sv
// Scoreboard for the text console writer: tracks the screen, predicts each item and checks results.
module console_checker
    import tcw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ATTR_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [OPCODE_W-1:0]  opcode,
    input  logic [CHAR_W-1:0]    character,
    input  logic [ADDR_W-1:0]    cell_address,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [ROW_OUT_W-1:0] cursor_row,
    input  logic [COL_OUT_W-1:0] cursor_column,
    input  logic [ADDR_W-1:0]    cursor_index,
    input  logic [CELL_W-1:0]    cell_data,
    input  logic                 scrolled,
    output int                   mismatch_count,
    output int                   pending_count,
    output int                   scroll_count
);

    localparam int COLS       = COLUMNS_DEF;
    localparam int LINES      = ROWS_DEF;
    localparam int CELL_COUNT = COLS * LINES;
    localparam int PRINT_CAP  = 200;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] column;
        logic [ADDR_W-1:0]    index;
        logic [CELL_W-1:0]    data;
        logic                 scrolled;
    } cursor_report_t;

    logic [CELL_W-1:0] screen [CELL_COUNT];
    int                row_pos;
    int                col_pos;
    logic [ATTR_W-1:0] text_attr;
    logic [ATTR_W-1:0] clear_attr;
    cursor_report_t    cursor_reports_q [$];

    assign pending_count = cursor_reports_q.size();

    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        end
        mismatch_count++;
    endtask

    // Applies one item to the screen copy and returns the result the block should give.
    task automatic predict_console_item(input logic [OPCODE_W-1:0] op,
                                        input logic [CHAR_W-1:0] ch,
                                        input logic [ADDR_W-1:0] addr,
                                        output cursor_report_t rep);
        logic wrap;
        int   pos;
        rep  = '0;
        wrap = 1'b0;
        case (op)
            OP_PUT:
            begin
                if (ch != NEWLINE_CODE)
                begin
                    screen[row_pos * COLS + col_pos] = {text_attr, ch};
                    col_pos++;
                    if (col_pos >= COLS)
                    begin
                        wrap = 1'b1;
                    end
                end
                else
                begin
                    wrap = 1'b1;
                end
                if (wrap)
                begin
                    col_pos = 0;
                    row_pos++;
                    if (row_pos >= LINES)
                    begin
                        for (pos = 0; pos + COLS < CELL_COUNT; pos++)
                        begin
                            screen[pos] = screen[pos + COLS];
                        end
                        for (pos = CELL_COUNT - COLS; pos < CELL_COUNT; pos++)
                        begin
                            screen[pos] = {clear_attr, SPACE_CODE};
                        end
                        row_pos      = LINES - 1;
                        rep.scrolled = 1'b1;
                        scroll_count++;
                    end
                end
            end
            OP_CLEAR:
            begin
                for (pos = 0; pos < CELL_COUNT; pos++)
                begin
                    screen[pos] = {clear_attr, SPACE_CODE};
                end
                row_pos = 0;
                col_pos = 0;
            end
            OP_READ:
            begin
                if (addr < CELL_COUNT)
                begin
                    rep.data = screen[addr];
                end
            end
            default:
            begin
            end
        endcase
        rep.row    = row_pos[ROW_OUT_W-1:0];
        rep.column = col_pos[COL_OUT_W-1:0];
        rep.index  = ADDR_W'(row_pos * COLS + col_pos);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cursor_report_t want;
        cursor_report_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < CELL_COUNT; i++)
            begin
                screen[i] = RESET_CELL;
            end
            row_pos        = 0;
            col_pos        = 0;
            text_attr      = RESET_ATTR;
            clear_attr     = RESET_ATTR;
            mismatch_count = 0;
            scroll_count   = 0;
            cursor_reports_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TEXT_ATTR)
                begin
                    text_attr = cfg_data;
                end
                else if (cfg_index == CFG_CLEAR_ATTR)
                begin
                    clear_attr = cfg_data;
                end
            end
            // Results are checked before the same edge's input transfer is predicted.
            if (out_valid && out_ready)
            begin
                got = '{cursor_row, cursor_column, cursor_index, cell_data, scrolled};
                if (cursor_reports_q.size() == 0)
                begin
                    report_mismatch("unexpected result", 0, 32'(got.index));
                end
                else
                begin
                    want = cursor_reports_q.pop_front();
                    if (got.row != want.row)
                        report_mismatch("cursor_row", 32'(want.row), 32'(got.row));
                    if (got.column != want.column)
                        report_mismatch("cursor_column", 32'(want.column), 32'(got.column));
                    if (got.index != want.index)
                        report_mismatch("cursor_index", 32'(want.index), 32'(got.index));
                    if (got.data != want.data)
                        report_mismatch("cell_data", 32'(want.data), 32'(got.data));
                    if (got.scrolled != want.scrolled)
                        report_mismatch("scrolled", 32'(want.scrolled), 32'(got.scrolled));
                end
            end
            if (in_valid && in_ready)
            begin
                predict_console_item(opcode, character, cell_address, want);
                cursor_reports_q.push_back(want);
            end
        end
    end

endmodule

### tb/text_console_writer_tb.sv
// Top of the text console writer testbench: clock, reset, stimulus, watchdog and verdict.
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 255;
    localparam int SEGMENT_ITEMS = 40;
    localparam int QUIET_LIMIT   = 12000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ATTR_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [CHAR_W-1:0]    character;
    logic [ADDR_W-1:0]    cell_address;
    logic                 out_valid;
    logic                 out_ready;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_column;
    logic [ADDR_W-1:0]    cursor_index;
    logic [CELL_W-1:0]    cell_data;
    logic                 scrolled;

    int mismatch_count;
    int pending_count;
    int scroll_count;
    bit idle_enable;
    int items_sent;
    int clears_sent;
    int reads_sent;

    text_console_writer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .character    (character),
        .cell_address (cell_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cursor_row   (cursor_row),
        .cursor_column(cursor_column),
        .cursor_index (cursor_index),
        .cell_data    (cell_data),
        .scrolled     (scrolled)
    );

    console_checker u_console_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .character     (character),
        .cell_address  (cell_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cursor_row    (cursor_row),
        .cursor_column (cursor_column),
        .cursor_index  (cursor_index),
        .cell_data     (cell_data),
        .scrolled      (scrolled),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count),
        .scroll_count  (scroll_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Holds each item on the bus until the transfer happens.
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [ADDR_W-1:0] addr);
        @(negedge clk);
        in_valid     = 1'b1;
        opcode       = op;
        character    = ch;
        cell_address = addr;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (op == OP_CLEAR)
            clears_sent++;
        if (op == OP_READ)
            reads_sent++;
    endtask

    function automatic logic [OPCODE_W-1:0] OP_OPCODE_JUNK();
        return OPCODE_W'($urandom_range(0, 3));
    endfunction

    task automatic hold_off(input int cycles);
        @(negedge clk);
        in_valid     = 1'b0;
        opcode       = OP_OPCODE_JUNK();
        character    = CHAR_W'($urandom_range(0, 255));
        cell_address = ADDR_W'($urandom_range(0, 2047));
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [ATTR_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending_count == 0);
        repeat (4) @(negedge clk);
    endtask

    // Mostly put traffic; the newline rate changes per segment so that some stretches
    // run lines to the last column and others walk the cursor down to force scrolls.
    task automatic send_random_item(input int newline_pct);
        int pick;
        logic [CHAR_W-1:0] ch;
        pick = $urandom_range(0, 99);
        if (pick < 1)
        begin
            send_item(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                      ADDR_W'($urandom_range(0, 2047)));
        end
        else if (pick < 3)
        begin
            send_item(OP_UNUSED, CHAR_W'($urandom_range(0, 255)),
                      ADDR_W'($urandom_range(0, 2047)));
        end
        else if (pick < 15)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(OP_READ, CHAR_W'($urandom_range(0, 255)),
                          ADDR_W'($urandom_range(2000, 2047)));
            else
                send_item(OP_READ, CHAR_W'($urandom_range(0, 255)),
                          ADDR_W'($urandom_range(0, 1999)));
        end
        else
        begin
            if ($urandom_range(0, 99) < newline_pct)
                ch = NEWLINE_CODE;
            else
                ch = CHAR_W'($urandom_range(0, 255));
            send_item(OP_PUT, ch, ADDR_W'($urandom_range(0, 2047)));
        end
    endtask

    task automatic send_directed_items();
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_READ, 8'hFF, 11'd1999);
        send_item(OP_READ, 8'h00, 11'd2000);
        send_item(OP_READ, 8'h00, 11'h7FF);
        send_item(OP_UNUSED, 8'hFF, 11'h7FF);
        send_item(OP_PUT, 8'h00, 11'h7FF);
        send_item(OP_PUT, 8'hFF, 11'd0);
        send_item(OP_PUT, NEWLINE_CODE, 11'd0);
        send_item(OP_PUT, 8'h41, 11'd0);
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_READ, 8'h00, 11'd1);
        send_item(OP_READ, 8'h00, 11'd80);
        send_item(OP_CLEAR, 8'hFF, 11'h7FF);
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_READ, 8'h00, 11'd1999);
        send_item(OP_PUT, 8'h55, 11'd0);
        send_item(OP_PUT, 8'hAA, 11'd0);
        send_item(OP_READ, 8'hFF, 11'd1);
        send_item(OP_CLEAR, 8'h00, 11'd0);
        send_item(OP_READ, 8'h00, 11'd1);
    endtask

    // While idle_enable is set, receiver stalls come in bursts of random length, separated by runs of plain acceptance.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_enable && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 13);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either channel for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: %0d cycles without a transfer, %0d results outstanding",
                 QUIET_LIMIT, pending_count);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [ATTR_W-1:0] text_settings  [PHASES];
        logic [ATTR_W-1:0] clear_settings [PHASES];
        int newline_pct;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_TEXT_ATTR;
        cfg_data     = '0;
        in_valid     = 1'b0;
        opcode       = OP_PUT;
        character    = '0;
        cell_address = '0;
        idle_enable  = 1'b1;
        items_sent   = 0;
        clears_sent  = 0;
        reads_sent   = 0;
        newline_pct  = 12;
        text_settings  = '{RESET_ATTR, 8'h00, 8'hFF, ATTR_W'($urandom_range(0, 255)),
                           ATTR_W'($urandom_range(0, 255))};
        clear_settings = '{RESET_ATTR, 8'hFF, 8'h00, ATTR_W'($urandom_range(0, 255)),
                           ATTR_W'($urandom_range(0, 255))};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Configuration is left alone until the post-reset clearing pass has finished.
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_until_drained();
                write_register(CFG_TEXT_ATTR, text_settings[phase]);
                write_register(CFG_CLEAR_ATTR, clear_settings[phase]);
            end
            idle_enable = (phase < PHASES - 1);
            if (phase == 0)
            begin
                send_directed_items();
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % SEGMENT_ITEMS == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: newline_pct = 1;
                        1: newline_pct = 12;
                        default: newline_pct = 60;
                    endcase
                end
                if (idle_enable && $urandom_range(0, 5) == 0)
                    hold_off($urandom_range(1, 13));
                send_random_item(newline_pct);
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        wait (pending_count == 0);
        repeat (30) @(posedge clk);

        $display("Covered %0d items (%0d clears, %0d reads), %0d scrolls, %0d attribute settings",
                 items_sent, clears_sent, reads_sent, scroll_count, PHASES);
        $display("Mismatches found: %0d", mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
